// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/e820m_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e820m_pkg
// Types, constants and the type-class table of the e820 map merger.
// ----------------------------------------------------------------------------
package e820m_pkg;

	localparam int unsigned MAX_DESCRIPTORS = 128;
	localparam int unsigned PAGE_SHIFT      = 12;
	localparam int unsigned QUEUE_DEPTH     = 4;
	localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CLS_NONE     = 3'd0;
	localparam logic [2:0] CLS_RAM      = 3'd1;
	localparam logic [2:0] CLS_RESERVED = 3'd2;
	localparam logic [2:0] CLS_ACPI     = 3'd3;
	localparam logic [2:0] CLS_NVS      = 3'd4;
	localparam logic [2:0] CLS_UNUSABLE = 3'd5;

	typedef struct packed {
		logic        present;
		logic [63:0] start;
		logic [63:0] length;
		logic [2:0]  etype;
		logic [6:0]  index;
		logic [7:0]  map_entries;
		logic        last;
	} result_t;

	// Up to two results caused by one item; a is always delivered first.
	typedef struct packed {
		logic    two;
		result_t a;
		result_t b;
	} result_pair_t;

	function automatic logic [2:0] class_of(input logic [3:0] code);
		logic [2:0] cls;
		unique case (code)
			4'd0, 4'd5, 4'd6, 4'd11, 4'd12, 4'd13: cls = CLS_RESERVED;
			4'd1, 4'd2, 4'd3, 4'd4, 4'd7:          cls = CLS_RAM;
			4'd8:                                  cls = CLS_UNUSABLE;
			4'd9:                                  cls = CLS_ACPI;
			4'd10:                                 cls = CLS_NVS;
			default:                               cls = CLS_NONE;
		endcase
		return cls;
	endfunction

endpackage

// ----- rtl/core/e820m_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e820m_front
// Classifies descriptors, merges them into the held entry and builds results.
// ----------------------------------------------------------------------------
module e820m_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [3:0]              mem_type,
	input  logic [63:0]             region_start,
	input  logic [51:0]             page_count,
	input  logic                    end_of_map,
	output logic                    push,
	output e820m_pkg::result_pair_t push_data
);
	import e820m_pkg::*;

	logic        held_valid_q;
	logic [63:0] held_start_q;
	logic [63:0] held_length_q;
	logic [2:0]  held_type_q;
	logic [7:0]  seen_q;
	logic [7:0]  emitted_q;

	logic        in_range;
	logic [2:0]  cls;
	logic        classed;
	logic [63:0] len;
	logic [63:0] held_end;
	logic [64:0] sum;
	logic        adjacent;
	logic        merge;
	logic        displace;
	logic        held_valid_d;
	logic [63:0] held_start_d;
	logic [63:0] held_length_d;
	logic [2:0]  held_type_d;
	logic [7:0]  emitted_after;
	result_t     disp_res;
	result_t     end_res;

	assign in_range = seen_q < 8'(MAX_DESCRIPTORS);
	assign cls      = class_of(mem_type);
	assign classed  = in_range && (cls != CLS_NONE);
	assign len      = 64'(page_count) << PAGE_SHIFT;
	assign held_end = held_start_q + held_length_q;
	assign sum      = {1'b0, held_length_q} + {1'b0, len};
	assign adjacent = held_valid_q && (held_type_q == cls) && (held_end == region_start);
	assign merge    = classed && adjacent;
	assign displace = classed && !adjacent && held_valid_q;

	always_comb begin
		held_valid_d  = held_valid_q || classed;
		held_start_d  = held_start_q;
		held_length_d = held_length_q;
		held_type_d   = held_type_q;
		if (merge) begin
			held_length_d = sum[64] ? '1 : sum[63:0];
		end else if (classed) begin
			held_start_d  = region_start;
			held_length_d = len;
			held_type_d   = cls;
		end
	end

	assign emitted_after = emitted_q + 8'(displace);

	always_comb begin
		disp_res.present     = 1'b1;
		disp_res.start       = held_start_q;
		disp_res.length      = held_length_q;
		disp_res.etype       = held_type_q;
		disp_res.index       = emitted_q[6:0];
		disp_res.map_entries = '0;
		disp_res.last        = 1'b0;
		if (held_valid_d) begin
			end_res.present     = 1'b1;
			end_res.start       = held_start_d;
			end_res.length      = held_length_d;
			end_res.etype       = held_type_d;
			end_res.index       = emitted_after[6:0];
			end_res.map_entries = emitted_after + 8'd1;
		end else begin
			end_res.present     = 1'b0;
			end_res.start       = '0;
			end_res.length      = '0;
			end_res.etype       = CLS_NONE;
			end_res.index       = '0;
			end_res.map_entries = emitted_after;
		end
		end_res.last = 1'b1;
	end

	assign push          = take && (displace || end_of_map);
	assign push_data.two = displace && end_of_map;
	assign push_data.a   = displace ? disp_res : end_res;
	assign push_data.b   = end_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			held_start_q  <= '0;
			held_length_q <= '0;
			held_type_q   <= CLS_NONE;
			seen_q        <= '0;
			emitted_q     <= '0;
		end else if (take) begin
			if (end_of_map) begin
				held_valid_q  <= 1'b0;
				held_start_q  <= '0;
				held_length_q <= '0;
				held_type_q   <= CLS_NONE;
				seen_q        <= '0;
				emitted_q     <= '0;
			end else begin
				held_valid_q  <= held_valid_d;
				held_start_q  <= held_start_d;
				held_length_q <= held_length_d;
				held_type_q   <= held_type_d;
				seen_q        <= seen_q + 8'(in_range);
				emitted_q     <= emitted_after;
			end
		end
	end

endmodule

// ----- rtl/core/e820m_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e820m_queue
// Short FIFO of result pairs between the front and the back.
// ----------------------------------------------------------------------------
module e820m_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  e820m_pkg::result_pair_t push_data,
	input  logic                    pop,
	output e820m_pkg::result_pair_t pop_data,
	output logic                    full,
	output logic                    empty
);
	import e820m_pkg::*;

	result_pair_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

endmodule

// ----- rtl/core/e820m_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e820m_back
// Splits queued result pairs and drives the registered output channel.
// ----------------------------------------------------------------------------
module e820m_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  e820m_pkg::result_pair_t q_data,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output e820m_pkg::result_t      out_res
);
	import e820m_pkg::*;

	logic    out_valid_q;
	result_t out_q;
	logic    sec_valid_q;
	result_t sec_q;
	logic    load;

	assign load      = !out_valid_q || out_ready;
	assign q_pop     = load && !sec_valid_q && !q_empty;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (load) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= !q_empty;
				sec_valid_q <= !q_empty && q_data.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_valid_q) begin
				out_q <= sec_q;
			end else if (!q_empty) begin
				out_q <= q_data.a;
				sec_q <= q_data.b;
			end
		end
	end

endmodule

// ----- rtl/core/memory_map_to_e820_merger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_to_e820_merger
// Firmware memory descriptors in, merged e820 table entries out.
// ----------------------------------------------------------------------------
// One descriptor is accepted per cycle while the queue is not full; the merge
// against the held entry (one 64-bit add and compare) finishes in the cycle of
// acceptance. Results pass through a four-deep queue of result pairs to a
// registered output, which delivers one entry per cycle while out_ready is
// high, so a descriptor that both displaces the held entry and ends the map
// gives two entries. Each result is queued, then registered at the output.
module memory_map_to_e820_merger (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mem_type,
	input  logic [63:0] region_start,
	input  logic [51:0] page_count,
	input  logic        end_of_map,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        entry_present,
	output logic [63:0] entry_start,
	output logic [63:0] entry_length,
	output logic [2:0]  entry_type,
	output logic [6:0]  entry_index,
	output logic [7:0]  map_entries,
	output logic        last_entry
);
	import e820m_pkg::*;

	`include "assert_macros.svh"

	logic         take;
	logic         push;
	result_pair_t push_data;
	result_pair_t q_data;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;
	result_t      out_res;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	e820m_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.mem_type     (mem_type),
		.region_start (region_start),
		.page_count   (page_count),
		.end_of_map   (end_of_map),
		.push         (push),
		.push_data    (push_data)
	);

	e820m_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	e820m_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign entry_present = out_res.present;
	assign entry_start   = out_res.start;
	assign entry_length  = out_res.length;
	assign entry_type    = out_res.etype;
	assign entry_index   = out_res.index;
	assign map_entries   = out_res.map_entries;
	assign last_entry    = out_res.last;

	`ASSERT_CLK(a_empty_marker_last, out_valid && !entry_present |-> last_entry && entry_type == CLS_NONE, "bad end marker")
	`ASSERT_CLK(a_count_only_last, out_valid && !last_entry |-> map_entries == 8'd0, "count on non-final entry")
	`ASSERT_CLK(a_present_typed, out_valid && entry_present |-> entry_type != CLS_NONE, "entry without class")
	`ASSERT_NEVER(a_push_when_full, push && q_full, "push into full queue")

endmodule

// ----- bench/memory_map_to_e820_merger_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_to_e820_merger_test
// Drives firmware memory maps into the merger and checks each e820 entry
// against an in-bench model of the type mapping, merge and end-of-map logic.
// A short table of hand-picked descriptors comes first, then a map that runs
// past the descriptor limit, then random maps under three idling patterns.
// ----------------------------------------------------------------------------
module memory_map_to_e820_merger_test;
	import e820m_pkg::*;

	localparam logic [3:0] FW_RESERVED     = 4'd0;
	localparam logic [3:0] FW_LOADER_CODE  = 4'd1;
	localparam logic [3:0] FW_LOADER_DATA  = 4'd2;
	localparam logic [3:0] FW_BS_CODE      = 4'd3;
	localparam logic [3:0] FW_BS_DATA      = 4'd4;
	localparam logic [3:0] FW_RT_CODE      = 4'd5;
	localparam logic [3:0] FW_RT_DATA      = 4'd6;
	localparam logic [3:0] FW_CONVENTIONAL = 4'd7;
	localparam logic [3:0] FW_UNUSABLE     = 4'd8;
	localparam logic [3:0] FW_ACPI_RECLAIM = 4'd9;
	localparam logic [3:0] FW_ACPI_NVS     = 4'd10;
	localparam logic [3:0] FW_MMIO         = 4'd11;
	localparam logic [3:0] FW_MMIO_PORT    = 4'd12;
	localparam logic [3:0] FW_PAL_CODE     = 4'd13;
	localparam logic [3:0] FW_UNKNOWN_A    = 4'd14;
	localparam logic [3:0] FW_UNKNOWN_B    = 4'd15;

	localparam int      STALL_LIMIT  = 5000;
	localparam int      SETTLE_CYCLES = 10;
	localparam result_t NO_RESULT    = '0;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TOP_PAGE = 64'hFFFF_FFFF_FFFF_F000;

	typedef struct {
		logic [3:0]  code;
		logic [63:0] start;
		logic [51:0] pages;
		logic        eom;
		bit          fixed;
		result_t     want;
	} descriptor_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  mem_type;
	logic [63:0] region_start;
	logic [51:0] page_count;
	logic        end_of_map;
	logic        out_valid;
	logic        out_ready;
	logic        entry_present;
	logic [63:0] entry_start;
	logic [63:0] entry_length;
	logic [2:0]  entry_type;
	logic [6:0]  entry_index;
	logic [7:0]  map_entries;
	logic        last_entry;

	result_t     pending_entries[$];
	descriptor_t directed_map[$];

	logic        held_valid;
	logic [63:0] held_start;
	logic [63:0] held_length;
	logic [2:0]  held_class;
	logic [7:0]  seen_count;
	logic [7:0]  emitted_count;

	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles = 0;

	memory_map_to_e820_merger dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mem_type(mem_type),
		.region_start(region_start),
		.page_count(page_count),
		.end_of_map(end_of_map),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.entry_present(entry_present),
		.entry_start(entry_start),
		.entry_length(entry_length),
		.entry_type(entry_type),
		.entry_index(entry_index),
		.map_entries(map_entries),
		.last_entry(last_entry)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [2:0] e820_class_for(input logic [3:0] code);
		case (code)
			FW_RESERVED, FW_RT_CODE, FW_RT_DATA, FW_MMIO, FW_MMIO_PORT, FW_PAL_CODE:
				return CLS_RESERVED;
			FW_LOADER_CODE, FW_LOADER_DATA, FW_BS_CODE, FW_BS_DATA, FW_CONVENTIONAL:
				return CLS_RAM;
			FW_UNUSABLE:     return CLS_UNUSABLE;
			FW_ACPI_RECLAIM: return CLS_ACPI;
			FW_ACPI_NVS:     return CLS_NVS;
			default:         return CLS_NONE;
		endcase
	endfunction

	task automatic clear_map();
		held_valid    = 1'b0;
		held_start    = '0;
		held_length   = '0;
		held_class    = CLS_NONE;
		seen_count    = '0;
		emitted_count = '0;
	endtask

	task automatic queue_held(input bit closes_map);
		result_t r;
		r.present     = 1'b1;
		r.start       = held_start;
		r.length      = held_length;
		r.etype       = held_class;
		r.index       = emitted_count[6:0];
		emitted_count = emitted_count + 8'd1;
		r.map_entries = closes_map ? emitted_count : 8'd0;
		r.last        = closes_map;
		pending_entries.push_back(r);
	endtask

	task automatic predict_entries(input descriptor_t d);
		logic [2:0]  cls;
		logic [63:0] len;
		logic [64:0] sum;
		result_t     marker;
		if (seen_count < MAX_DESCRIPTORS) begin
			cls = e820_class_for(d.code);
			seen_count = seen_count + 8'd1;
			if (cls != CLS_NONE) begin
				len = 64'(d.pages) << PAGE_SHIFT;
				if (held_valid && held_class == cls && 64'(held_start + held_length) == d.start) begin
					sum = {1'b0, held_length} + {1'b0, len};
					held_length = sum[64] ? ALL_ONES : sum[63:0];
				end else begin
					if (held_valid)
						queue_held(1'b0);
					held_valid  = 1'b1;
					held_start  = d.start;
					held_length = len;
					held_class  = cls;
				end
			end
		end
		if (d.eom) begin
			if (held_valid) begin
				queue_held(1'b1);
			end else begin
				marker = '0;
				marker.map_entries = emitted_count;
				marker.last = 1'b1;
				pending_entries.push_back(marker);
			end
			clear_map();
		end
	endtask

	task automatic add_row(input logic [3:0] code, input logic [63:0] start,
			input logic [51:0] pages, input logic eom, input bit fixed, input result_t want);
		descriptor_t d;
		d.code  = code;
		d.start = start;
		d.pages = pages;
		d.eom   = eom;
		d.fixed = fixed;
		d.want  = want;
		directed_map.push_back(d);
	endtask

	task automatic send_descriptor(input descriptor_t d);
		int queued;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid     = 1'b1;
		mem_type     = d.code;
		region_start = d.start;
		page_count   = d.pages;
		end_of_map   = d.eom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		queued = pending_entries.size();
		predict_entries(d);
		if (d.fixed) begin
			while (pending_entries.size() > queued)
				void'(pending_entries.pop_back());
			pending_entries.push_back(d.want);
		end
	endtask

	task automatic wait_for_entries();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
	endtask

	// Most descriptors after the first in a map continue the previous region so that merges happen;
	// the rest land anywhere. Now and then a map runs past the limit.
	task automatic send_random_maps(input int budget);
		descriptor_t d;
		logic [63:0] next_start;
		logic [3:0]  prev_code;
		int          map_len;
		while (budget > 0) begin
			map_len = ($urandom_range(0, 29) == 0) ? $urandom_range(124, 136)
				: $urandom_range(1, 12);
			next_start = {$urandom, $urandom};
			prev_code  = 4'($urandom_range(0, 13));
			for (int i = 0; i < map_len; i++) begin
				d.fixed = 1'b0;
				d.want  = NO_RESULT;
				d.eom   = (i == map_len - 1);
				if (i > 0 && $urandom_range(0, 99) < 55) begin
					d.start = next_start;
					d.code  = ($urandom_range(0, 99) < 60) ? prev_code
						: 4'($urandom_range(0, 13));
				end else begin
					d.start = $urandom_range(0, 1) ? {$urandom, $urandom}
						: 64'($urandom_range(0, 4095)) << PAGE_SHIFT;
					d.code  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15))
						: 4'($urandom_range(0, 13));
				end
				case ($urandom_range(0, 19))
					0:          d.pages = '0;
					1:          d.pages = '1;
					2, 3, 4, 5: d.pages = 52'({$urandom, $urandom});
					default:    d.pages = 52'($urandom_range(1, 64));
				endcase
				next_start = d.start + (64'(d.pages) << PAGE_SHIFT);
				prev_code  = d.code;
				send_descriptor(d);
				budget--;
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_entries.size() == 0) begin
				errors++;
				$display("%0t: unexpected entry, start %0h type %0d last %0b",
					$time, entry_start, entry_type, last_entry);
			end else begin
				want = pending_entries.pop_front();
				compare_field("entry_present", 64'(want.present), 64'(entry_present));
				compare_field("entry_start", want.start, entry_start);
				compare_field("entry_length", want.length, entry_length);
				compare_field("entry_type", 64'(want.etype), 64'(entry_type));
				compare_field("entry_index", 64'(want.index), 64'(entry_index));
				compare_field("map_entries", 64'(want.map_entries), 64'(map_entries));
				compare_field("last_entry", 64'(want.last), 64'(last_entry));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("[memory_map_to_e820_merger] ERROR");
				$finish;
			end
		end
	end

	initial begin
		descriptor_t d;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mem_type      = '0;
		region_start  = '0;
		page_count    = '0;
		end_of_map    = 1'b0;
		errors        = 0;
		send_idle_pct = 21;
		recv_idle_pct = 63;
		clear_map();

		// empty map, then a lone RAM page
		add_row(FW_UNKNOWN_A, 64'h0, 52'h0, 1'b1, 1'b1,
			'{1'b0, 64'h0, 64'h0, CLS_NONE, 7'd0, 8'd0, 1'b1});
		add_row(FW_CONVENTIONAL, 64'h1000, 52'd1, 1'b1, 1'b1,
			'{1'b1, 64'h1000, 64'h1000, CLS_RAM, 7'd0, 8'd1, 1'b1});
		// every firmware code but FW_UNKNOWN_A, merges and class changes, two entries on the end mark
		add_row(FW_RESERVED, 64'h0, 52'd1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_RT_CODE, 64'h1000, 52'd2, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_LOADER_CODE, 64'h3000, 52'd1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_LOADER_DATA, 64'h4000, 52'd1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_BS_CODE, 64'h5000, 52'd1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_BS_DATA, 64'h6000, 52'd0, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_CONVENTIONAL, 64'h6000, 52'hFFFF, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_UNUSABLE, 64'h1_0000_0000, 52'd4, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_UNKNOWN_B, 64'h1_0000_4000, 52'd4, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_ACPI_RECLAIM, 64'h2_0000_0000, 52'd8, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_ACPI_NVS, 64'h2_0000_8000, 52'd8, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_MMIO, 64'hFEC0_0000, 52'd1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_MMIO_PORT, 64'hFEC0_1000, 52'd1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_PAL_CODE, 64'hFEC0_2000, 52'd1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_RT_DATA, 64'h8000_0000, 52'd16, 1'b1, 1'b0, NO_RESULT);
		// widest page count at the top address: length keeps its low 64 bits
		add_row(FW_CONVENTIONAL, ALL_ONES, '1, 1'b1, 1'b1,
			'{1'b1, ALL_ONES, TOP_PAGE, CLS_RAM, 7'd0, 8'd1, 1'b1});
		// merged length saturates
		add_row(FW_CONVENTIONAL, 64'h0, '1, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_LOADER_CODE, TOP_PAGE, 52'd2, 1'b1, 1'b1,
			'{1'b1, 64'h0, ALL_ONES, CLS_RAM, 7'd0, 8'd1, 1'b1});
		// region end wraps past zero and still counts as adjacent
		add_row(FW_ACPI_RECLAIM, TOP_PAGE, 52'd2, 1'b0, 1'b0, NO_RESULT);
		add_row(FW_ACPI_RECLAIM, 64'h1000, 52'd1, 1'b1, 1'b1,
			'{1'b1, TOP_PAGE, 64'h3000, CLS_ACPI, 7'd0, 8'd1, 1'b1});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_map[i])
			send_descriptor(directed_map[i]);

		// past the descriptor limit; the end mark on an ignored descriptor still closes
		for (int i = 0; i < MAX_DESCRIPTORS + 2; i++) begin
			d.code  = FW_MMIO;
			d.start = {$urandom, $urandom};
			d.pages = 52'($urandom_range(1, 16));
			d.eom   = (i == MAX_DESCRIPTORS + 1);
			d.fixed = 1'b0;
			d.want  = NO_RESULT;
			send_descriptor(d);
		end

		send_random_maps(210);
		wait_for_entries();
		send_idle_pct = 63;
		recv_idle_pct = 21;
		send_random_maps(220);
		wait_for_entries();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_maps(220);
		wait_for_entries();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[memory_map_to_e820_merger] OK");
		else
			$display("[memory_map_to_e820_merger] ERROR");
		$finish;
	end

endmodule

// ----- memory_map_to_e820_merger.f -----
+incdir+rtl/core
rtl/core/e820m_pkg.sv
rtl/core/e820m_front.sv
rtl/core/e820m_queue.sv
rtl/core/e820m_back.sv
rtl/core/memory_map_to_e820_merger.sv
bench/memory_map_to_e820_merger_test.sv
